[rtl/c3vs_pkg.sv]
`timescale 1ns / 1ps

package c3vs_pkg;

   localparam int MAX_WIDTH_DEF  = 128;
   localparam int PIXEL_BITS_DEF = 16;
   localparam int COEF_BITS_DEF  = 8;

   localparam int IMG_W_BITS     = 8;
   localparam int IMG_H_BITS     = 10;
   localparam int OUT_VALUE_BITS = 27;
   localparam int OUT_ROW_BITS   = 10;
   localparam int OUT_COL_BITS   = 7;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KERNEL_MID    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd4;

   localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 8'd28;
   localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 10'd28;

   typedef struct packed {
      logic [IMG_W_BITS-1:0] width;
      logic [IMG_H_BITS-1:0] height;
   } size_type;

   typedef struct packed {
      logic                    last;
      logic [OUT_ROW_BITS-1:0] row;
      logic [OUT_COL_BITS-1:0] col;
   } pos_type;

endpackage

[rtl/c3vs_csr.sv]
`timescale 1ns / 1ps

module c3vs_csr #(
   parameter int COEF_BITS = c3vs_pkg::COEF_BITS_DEF,
   parameter int DATA_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [c3vs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DATA_BITS-1:0]                 csr_wdata,
   output logic [3*COEF_BITS-1:0]               kernel [3],
   output c3vs_pkg::size_type                   size
);
   import c3vs_pkg::*;

   logic [3*COEF_BITS-1:0] kernel_ff [3];
   size_type               size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0]   <= '0;
         kernel_ff[1]   <= '0;
         kernel_ff[2]   <= '0;
         size_ff.width  <= WIDTH_RESET;
         size_ff.height <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_KERNEL_TOP:    kernel_ff[0]   <= csr_wdata[3*COEF_BITS-1:0];
            REG_KERNEL_MID:    kernel_ff[1]   <= csr_wdata[3*COEF_BITS-1:0];
            REG_KERNEL_BOTTOM: kernel_ff[2]   <= csr_wdata[3*COEF_BITS-1:0];
            REG_IMAGE_WIDTH:   size_ff.width  <= csr_wdata[IMG_W_BITS-1:0];
            REG_IMAGE_HEIGHT:  size_ff.height <= csr_wdata[IMG_H_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign kernel = kernel_ff;
   assign size   = size_ff;

endmodule

[rtl/c3vs_window.sv]
`timescale 1ns / 1ps

module c3vs_window #(
   parameter int MAX_WIDTH  = c3vs_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = c3vs_pkg::PIXEL_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  c3vs_pkg::size_type       size,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [PIXEL_BITS-1:0]    in_pixel,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [PIXEL_BITS-1:0]    out_window [9],
   output c3vs_pkg::pos_type        out_pos
);
   import c3vs_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int LW = ((CW > IMG_W_BITS) ? CW : IMG_W_BITS) + 1;

   logic [CW-1:0]          col_ff, col_in, w_last;
   logic [IMG_H_BITS-1:0]  row_ff, row_in, h_last;
   logic [LW-1:0]          w_x, w_last_x;
   logic [CW+OUT_COL_BITS-1:0] col_x;

   logic                   accept, s1_move, s2_ready;
   logic                   emit_in;
   pos_type                pos_in;

   logic                   s1_vld_ff, s1_emit_ff;
   logic [PIXEL_BITS-1:0]  s1_pix_ff;
   logic [CW-1:0]          s1_col_ff;
   pos_type                s1_pos_ff;
   logic [PIXEL_BITS-1:0]  above1_ff, above2_ff;

   logic                   s2_vld_ff;
   pos_type                s2_pos_ff;
   logic [PIXEL_BITS-1:0]  win_ff [9];

   logic [PIXEL_BITS-1:0]  store_a [MAX_WIDTH];
   logic [PIXEL_BITS-1:0]  store_b [MAX_WIDTH];

   always_comb begin
      w_x = LW'(size.width);
      if (w_x < LW'(3)) begin
         w_last_x = LW'(2);
      end else if (w_x > LW'(MAX_WIDTH)) begin
         w_last_x = LW'(MAX_WIDTH - 1);
      end else begin
         w_last_x = w_x - LW'(1);
      end
      w_last = w_last_x[CW-1:0];
      if (size.height < IMG_H_BITS'(3)) begin
         h_last = IMG_H_BITS'(2);
      end else begin
         h_last = size.height - IMG_H_BITS'(1);
      end
   end

   assign s2_ready = !s2_vld_ff || out_ready;
   assign s1_move  = s1_vld_ff && s2_ready;
   assign in_ready = !s1_vld_ff || s2_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      col_x      = {{OUT_COL_BITS{1'b0}}, col_ff - CW'(2)};
      emit_in    = (row_ff >= IMG_H_BITS'(2)) && (col_ff >= CW'(2));
      pos_in.row = row_ff - IMG_H_BITS'(2);
      pos_in.col = col_x[OUT_COL_BITS-1:0];
      pos_in.last = (row_ff == h_last) && (col_ff == w_last);
      if (col_ff >= w_last) begin
         col_in = '0;
         row_in = (row_ff >= h_last) ? '0 : row_ff + IMG_H_BITS'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_move) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_move) begin
            s2_vld_ff <= s1_emit_ff;
         end else if (out_ready) begin
            s2_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= in_pixel;
         s1_col_ff  <= col_ff;
         s1_emit_ff <= emit_in;
         s1_pos_ff  <= pos_in;
      end
      if (s1_move) begin
         for (int m = 0; m < 3; m++) begin
            win_ff[m*3+0] <= win_ff[m*3+1];
            win_ff[m*3+1] <= win_ff[m*3+2];
         end
         win_ff[2] <= above2_ff;
         win_ff[5] <= above1_ff;
         win_ff[8] <= s1_pix_ff;
         s2_pos_ff <= s1_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         above1_ff <= store_a[col_ff];
         above2_ff <= store_b[col_ff];
      end
      if (s1_move) begin
         store_a[s1_col_ff] <= s1_pix_ff;
         store_b[s1_col_ff] <= above1_ff;
      end
   end

   assign out_valid  = s2_vld_ff;
   assign out_window = win_ff;
   assign out_pos    = s2_pos_ff;

`ifndef ASSERT_OFF
   a_last_has_result: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s1_pos_ff.last |-> s1_emit_ff)
      else $error("frame end marked on a border position");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s2_ready |=> s1_vld_ff && $stable(s1_pix_ff) && $stable(above1_ff))
      else $error("stalled item lost its line data");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= CW'(MAX_WIDTH - 1))
      else $error("column counter beyond line store");

   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && col_ff >= w_last |=> col_ff == '0)
      else $error("column counter failed to wrap");
`endif

endmodule

[rtl/c3vs_mac.sv]
`timescale 1ns / 1ps

module c3vs_mac #(
   parameter int PIXEL_BITS = c3vs_pkg::PIXEL_BITS_DEF,
   parameter int COEF_BITS  = c3vs_pkg::COEF_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic [PIXEL_BITS-1:0]                       in_window [9],
   input  c3vs_pkg::pos_type                           in_pos,
   input  logic [3*COEF_BITS-1:0]                      kernel [3],
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [c3vs_pkg::OUT_VALUE_BITS-1:0]  rsp_conv_value,
   output logic [c3vs_pkg::OUT_ROW_BITS-1:0]           rsp_out_row,
   output logic [c3vs_pkg::OUT_COL_BITS-1:0]           rsp_out_col,
   output logic                                        rsp_frame_last
);
   import c3vs_pkg::*;

   localparam int PW = PIXEL_BITS + COEF_BITS;
   localparam int SW = (PW + 4 > OUT_VALUE_BITS) ? PW + 4 : OUT_VALUE_BITS;

   logic signed [PW-1:0]         prod_in [9];
   logic signed [PW-1:0]         prod_ff [9];
   logic signed [SW-1:0]         sum;
   logic                         s3_vld_ff, rsp_vld_ff;
   logic                         s3_ready, rsp_free;
   pos_type                      s3_pos_ff, rsp_pos_ff;
   logic [OUT_VALUE_BITS-1:0]    conv_ff;

   always_comb begin
      for (int m = 0; m < 3; m++) begin
         for (int n = 0; n < 3; n++) begin
            prod_in[m*3+n] = PW'($signed(in_window[m*3+n]))
                           * PW'($signed(kernel[m][n*COEF_BITS +: COEF_BITS]));
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < 9; i++) begin
         sum = sum + SW'(prod_ff[i]);
      end
   end

   assign rsp_free = !rsp_vld_ff || rsp_ready;
   assign s3_ready = !s3_vld_ff || rsp_free;
   assign in_ready = s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s3_vld_ff <= in_valid;
         end
         if (rsp_free) begin
            rsp_vld_ff <= s3_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         prod_ff   <= prod_in;
         s3_pos_ff <= in_pos;
      end
      if (rsp_free && s3_vld_ff) begin
         conv_ff    <= sum[OUT_VALUE_BITS-1:0];
         rsp_pos_ff <= s3_pos_ff;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_conv_value = conv_ff;
   assign rsp_out_row    = rsp_pos_ff.row;
   assign rsp_out_col    = rsp_pos_ff.col;
   assign rsp_frame_last = rsp_pos_ff.last;

endmodule

[rtl/conv3x3_valid_stream.sv]
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_pixel
// rsp       out        rsp_valid/rsp_ready   rsp_conv_value, rsp_out_row, rsp_out_col,
//                                            rsp_frame_last
// csr       in         csr_wr_en             csr_index, csr_wdata
//
// One pixel per cycle while rsp is not stalled; after its pixel is taken, a result passes
// the line store read, window shift, product register and sum register, in that order.
// Border pixels update the line stores and window but give no result.
// Reset is synchronous: counters clear, kernel to zero, image size to 28 by 28.
// Line stores and window are not cleared; they fill during the first two rows.
// A stall on rsp fills the empty stages first, then holds req_ready low.
`timescale 1ns / 1ps

module conv3x3_valid_stream #(
   parameter int MAX_WIDTH  = c3vs_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = c3vs_pkg::PIXEL_BITS_DEF,
   parameter int COEF_BITS  = c3vs_pkg::COEF_BITS_DEF,
   parameter int CSR_DATA_BITS = (3 * COEF_BITS > c3vs_pkg::IMG_H_BITS) ?
                                 3 * COEF_BITS : c3vs_pkg::IMG_H_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [PIXEL_BITS-1:0]                req_pixel,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [c3vs_pkg::OUT_VALUE_BITS-1:0]  rsp_conv_value,
   output logic [c3vs_pkg::OUT_ROW_BITS-1:0]           rsp_out_row,
   output logic [c3vs_pkg::OUT_COL_BITS-1:0]           rsp_out_col,
   output logic                                        rsp_frame_last,
   input  logic                                        csr_wr_en,
   input  logic [c3vs_pkg::CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]                    csr_wdata
);
   import c3vs_pkg::*;

   logic [3*COEF_BITS-1:0]  kernel [3];
   size_type                size;
   logic                    win_valid, win_ready;
   logic [PIXEL_BITS-1:0]   win_pix [9];
   pos_type                 win_pos;

   c3vs_csr #(
      .COEF_BITS (COEF_BITS),
      .DATA_BITS (CSR_DATA_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .kernel    (kernel),
      .size      (size)
   );

   c3vs_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .size       (size),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_pixel   (req_pixel),
      .out_valid  (win_valid),
      .out_ready  (win_ready),
      .out_window (win_pix),
      .out_pos    (win_pos)
   );

   c3vs_mac #(
      .PIXEL_BITS (PIXEL_BITS),
      .COEF_BITS  (COEF_BITS)
   ) u_mac (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (win_valid),
      .in_ready       (win_ready),
      .in_window      (win_pix),
      .in_pos         (win_pos),
      .kernel         (kernel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_conv_value (rsp_conv_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
